/* hw/rtl/aces_tonemap_to_8bit_defines.svh */
// assertion macros for the tone mapper
`ifndef ACES_TONEMAP_TO_8BIT_DEFINES_SVH
`define ACES_TONEMAP_TO_8BIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ACTM_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ACTM_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define ACTM_ASSERT(name, prop, msg)
`define ACTM_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

/* hw/rtl/actm_pkg.sv */
package actm_pkg;

   localparam int FIELD_W  = 24;
   localparam int MAPPED_W = 17;
   localparam int CODE_W   = 8;
   localparam int NUM_CH   = 3;
   // quotient bits kept by the divider, curve stays below 4.0
   localparam int QUOT_W   = 18;

   localparam logic [MAPPED_W-1:0] ONE_Q16 = 17'h10000;
   localparam logic [CODE_W-1:0]   CODE_MAX = 8'hff;

   typedef struct packed {
      logic [FIELD_W-1:0] red_in;
      logic [FIELD_W-1:0] green_in;
      logic [FIELD_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [MAPPED_W-1:0] red_mapped;
      logic [MAPPED_W-1:0] green_mapped;
      logic [MAPPED_W-1:0] blue_mapped;
      logic [CODE_W-1:0]   red_code;
      logic [CODE_W-1:0]   green_code;
      logic [CODE_W-1:0]   blue_code;
   } rsp_type;

endpackage

/* hw/rtl/aces_tonemap_to_8bit.sv */
// channel   ports                  transfer
// request   start, busy, req_data  taken at an edge with start high and busy low
// result    rsp_valid, rsp_data    valid for one cycle, no back pressure
//
// one pixel per clock sustained outside reset, all three channels in parallel
// pipeline: input, two multiplier stages, dividend setup,
// an 18-stage restoring divider (one quotient bit per stage), output
// reset is synchronous and clears the valid bits; busy is high only in reset
// nothing stalls: every accepted request leaves in the order it was taken
`include "aces_tonemap_to_8bit_defines.svh"

module aces_tonemap_to_8bit #(
   parameter int FRAC_BITS = 16,
   parameter int INT_BITS  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  actm_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output actm_pkg::rsp_type rsp_data
);
   import actm_pkg::*;

   localparam int IN_W = (INT_BITS + FRAC_BITS < FIELD_W) ? INT_BITS + FRAC_BITS : FIELD_W;
   // below the saturation point x fits in FRAC_BITS+3 bits
   localparam int X_W  = (IN_W < FRAC_BITS + 3) ? IN_W : FRAC_BITS + 3;
   localparam int CW   = FRAC_BITS + 2;
   localparam int PW   = CW + X_W;
   localparam int TW   = FRAC_BITS + 5;
   localparam int MW   = X_W + TW;
   localparam int NW   = FRAC_BITS + 8;
   localparam int RW   = FRAC_BITS + 25;
   localparam int SW   = 25;

   localparam logic [CW-1:0] K_A = CW'(((64'd251 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [CW-1:0] K_B = CW'(((64'd3 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [CW-1:0] K_C = CW'(((64'd243 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [CW-1:0] K_D = CW'(((64'd59 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [CW-1:0] K_E = CW'(((64'd14 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [63:0]   SAT_LIMIT = 64'd8 << FRAC_BITS;
   localparam logic [FIELD_W-1:0] IN_MASK = FIELD_W'((64'd1 << IN_W) - 64'd1);

   logic                accept;
   logic [FIELD_W-1:0]  chan_raw [NUM_CH];
   logic [FIELD_W-1:0]  chan_masked [NUM_CH];

   // stage 1: masked input
   logic                s1_valid_ff;
   logic [NUM_CH-1:0]   s1_sat_in, s1_sat_ff;
   logic [X_W-1:0]      s1_x_in [NUM_CH];
   logic [X_W-1:0]      s1_x_ff [NUM_CH];

   // stage 2: first products
   logic                s2_valid_ff;
   logic [NUM_CH-1:0]   s2_sat_ff;
   logic [X_W-1:0]      s2_x_ff [NUM_CH];
   logic [PW-1:0]       s2_pa_in [NUM_CH];
   logic [PW-1:0]       s2_pa_ff [NUM_CH];
   logic [PW-1:0]       s2_pc_in [NUM_CH];
   logic [PW-1:0]       s2_pc_ff [NUM_CH];

   // stage 3: second products
   logic                s3_valid_ff;
   logic [NUM_CH-1:0]   s3_sat_ff;
   logic [TW-1:0]       s3_ta [NUM_CH];
   logic [TW-1:0]       s3_tc [NUM_CH];
   logic [MW-1:0]       s3_mn_in [NUM_CH];
   logic [MW-1:0]       s3_mn_ff [NUM_CH];
   logic [MW-1:0]       s3_md_in [NUM_CH];
   logic [MW-1:0]       s3_md_ff [NUM_CH];

   // divider: index 0 holds the dividend, index k has k quotient bits done
   logic [QUOT_W:0]     div_valid_ff;
   logic [NUM_CH-1:0]   div_sat_ff [QUOT_W+1];
   logic [NW-1:0]       div_num [NUM_CH];
   logic [NW-1:0]       div_den_in [QUOT_W+1][NUM_CH];
   logic [NW-1:0]       div_den_ff [QUOT_W+1][NUM_CH];
   logic [RW-1:0]       div_rem_in [QUOT_W+1][NUM_CH];
   logic [RW-1:0]       div_rem_ff [QUOT_W+1][NUM_CH];
   logic [QUOT_W-1:0]   div_q_in [QUOT_W+1][NUM_CH];
   logic [QUOT_W-1:0]   div_q_ff [QUOT_W+1][NUM_CH];
   logic [RW-1:0]       div_dsh [QUOT_W+1][NUM_CH];
   logic                div_ge [QUOT_W+1][NUM_CH];

   // output stage
   logic                rsp_valid_ff;
   logic [MAPPED_W-1:0] out_mapped [NUM_CH];
   logic [SW-1:0]       out_scaled [NUM_CH];
   logic [CODE_W-1:0]   out_code [NUM_CH];
   rsp_type             rsp_data_in, rsp_data_ff;

   assign busy   = reset;
   assign accept = start & ~busy;

   assign chan_raw[0] = req_data.red_in;
   assign chan_raw[1] = req_data.green_in;
   assign chan_raw[2] = req_data.blue_in;

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         chan_masked[ch] = chan_raw[ch] & IN_MASK;
         s1_x_in[ch]     = chan_masked[ch][X_W-1:0];
         s1_sat_in[ch]   = 64'(chan_masked[ch]) >= SAT_LIMIT;

         s2_pa_in[ch] = {{X_W{1'b0}}, K_A} * {{CW{1'b0}}, s1_x_ff[ch]};
         s2_pc_in[ch] = {{X_W{1'b0}}, K_C} * {{CW{1'b0}}, s1_x_ff[ch]};

         s3_ta[ch]    = TW'(s2_pa_ff[ch] >> FRAC_BITS) + TW'(K_B);
         s3_tc[ch]    = TW'(s2_pc_ff[ch] >> FRAC_BITS) + TW'(K_D);
         s3_mn_in[ch] = {{TW{1'b0}}, s2_x_ff[ch]} * {{X_W{1'b0}}, s3_ta[ch]};
         s3_md_in[ch] = {{TW{1'b0}}, s2_x_ff[ch]} * {{X_W{1'b0}}, s3_tc[ch]};

         // dividend is num * 2^16 plus half the divisor for rounding
         div_num[ch]       = NW'(s3_mn_ff[ch] >> FRAC_BITS);
         div_den_in[0][ch] = NW'(s3_md_ff[ch] >> FRAC_BITS) + NW'(K_E);
         div_rem_in[0][ch] = (RW'(div_num[ch]) << 16) + RW'(div_den_in[0][ch] >> 1);
         div_q_in[0][ch]   = '0;
         div_dsh[0][ch]    = '0;
         div_ge[0][ch]     = 1'b0;
      end

      for (int k = 1; k <= QUOT_W; k++) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            div_dsh[k][ch]    = RW'(div_den_ff[k-1][ch]) << (QUOT_W - k);
            div_ge[k][ch]     = div_rem_ff[k-1][ch] >= div_dsh[k][ch];
            div_rem_in[k][ch] = div_ge[k][ch] ? div_rem_ff[k-1][ch] - div_dsh[k][ch]
                                              : div_rem_ff[k-1][ch];
            div_q_in[k][ch]   = {div_q_ff[k-1][ch][QUOT_W-2:0], div_ge[k][ch]};
            div_den_in[k][ch] = div_den_ff[k-1][ch];
         end
      end

      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (div_sat_ff[QUOT_W][ch] || (div_q_ff[QUOT_W][ch] > QUOT_W'(ONE_Q16))) begin
            out_mapped[ch] = ONE_Q16;
         end else begin
            out_mapped[ch] = div_q_ff[QUOT_W][ch][MAPPED_W-1:0];
         end
         // times 255 as times 256 minus one, then round half up
         out_scaled[ch] = (SW'(out_mapped[ch]) << 8) - SW'(out_mapped[ch]) + SW'(32768);
         out_code[ch]   = out_scaled[ch][23:16];
      end

      rsp_data_in.red_mapped   = out_mapped[0];
      rsp_data_in.green_mapped = out_mapped[1];
      rsp_data_in.blue_mapped  = out_mapped[2];
      rsp_data_in.red_code     = out_code[0];
      rsp_data_in.green_code   = out_code[1];
      rsp_data_in.blue_code    = out_code[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         div_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         div_valid_ff <= {div_valid_ff[QUOT_W-1:0], s3_valid_ff};
         rsp_valid_ff <= div_valid_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      s1_sat_ff     <= s1_sat_in;
      s2_sat_ff     <= s1_sat_ff;
      s3_sat_ff     <= s2_sat_ff;
      div_sat_ff[0] <= s3_sat_ff;
      for (int k = 1; k <= QUOT_W; k++) begin
         div_sat_ff[k] <= div_sat_ff[k-1];
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s1_x_ff[ch]  <= s1_x_in[ch];
         s2_x_ff[ch]  <= s1_x_ff[ch];
         s2_pa_ff[ch] <= s2_pa_in[ch];
         s2_pc_ff[ch] <= s2_pc_in[ch];
         s3_mn_ff[ch] <= s3_mn_in[ch];
         s3_md_ff[ch] <= s3_md_in[ch];
         for (int k = 0; k <= QUOT_W; k++) begin
            div_rem_ff[k][ch] <= div_rem_in[k][ch];
            div_den_ff[k][ch] <= div_den_in[k][ch];
            div_q_ff[k][ch]   <= div_q_in[k][ch];
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_chk
      `ACTM_ASSERT(a_div_range, div_valid_ff[0] |-> ((div_rem_ff[0][ch] >> QUOT_W) < RW'(div_den_ff[0][ch])), "dividend exceeds quotient range")
      `ACTM_ASSERT(a_div_rem, div_valid_ff[QUOT_W] |-> (div_rem_ff[QUOT_W][ch] < RW'(div_den_ff[QUOT_W][ch])), "final remainder not below divisor")
   end

   `ACTM_ASSERT_NEXT(a_sat_out, div_valid_ff[QUOT_W] && div_sat_ff[QUOT_W][0], rsp_valid && rsp_data.red_mapped == ONE_Q16 && rsp_data.red_code == CODE_MAX, "saturated red did not map to full scale")
   `ACTM_ASSERT(a_mapped_max, rsp_valid |-> (rsp_data.red_mapped <= ONE_Q16 && rsp_data.green_mapped <= ONE_Q16 && rsp_data.blue_mapped <= ONE_Q16), "mapped value above one")

endmodule
